// ----- rtl/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants for the sample frame builder
// Item kinds passed from the front end to the byte sequencer, queue
// sizing, register map and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

    // Configuration register
    localparam int unsigned C_SPF_W       = 13;
    localparam logic [12:0] C_SPF_RESET   = 13'd2490;
    localparam logic [12:0] C_MAX_SAMPLES = 13'd4096;

    // Register map: one 32-bit register, word index taken from paddr[2]
    localparam int unsigned C_PADDR_W = 3;
    localparam logic        C_REG_SPF = 1'b0;

    // CRC-32, reflected
    localparam logic [31:0] C_CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] C_CRC_INIT = 32'hFFFF_FFFF;

    // Command queue
    localparam int unsigned C_Q_DEPTH = 4;
    localparam int unsigned C_Q_AW    = $clog2(C_Q_DEPTH);
    localparam int unsigned C_Q_CW    = $clog2(C_Q_DEPTH + 1);

    // Byte indexes within one command
    localparam logic [3:0] C_IDX_MARK_END = 4'd9;   // last marker byte
    localparam logic [3:0] C_IDX_HDR_LAST = 4'd15;  // last header byte
    localparam logic [3:0] C_IDX_SMP_LAST = 4'd1;   // last sample byte
    localparam logic [3:0] C_IDX_CRC_LAST = 4'd5;   // last trailer byte

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_SAMPLE,
        KIND_LAST
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  timestamp;
        logic [11:0]  encoder_position;
        logic [15:0]  sample;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One byte through the reflected CRC register
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] c_in,
                                                  input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ C_CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sfb_in_if.sv -----
// ----------------------------------------------------------------------------
// sfb_in_if: input item channel
// Valid/ready handshake carrying one header or sample item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfb_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [31:0]        timestamp;
    logic [11:0]        encoder_position;
    logic signed [15:0] sample;

    modport source (output valid, cmd, timestamp, encoder_position, sample,
                    input ready);
    modport sink   (input valid, cmd, timestamp, encoder_position, sample,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/sfb_out_if.sv -----
// ----------------------------------------------------------------------------
// sfb_out_if: output byte channel
// Valid/ready handshake carrying one frame byte and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/sample_frame_builder_crc32.sv -----
// ----------------------------------------------------------------------------
// sample_frame_builder_crc32: framed sample byte stream with CRC-32 trailer
// i_in takes header items (cmd 0) and sample items (cmd 1); o_out gives the
// frame one byte per transaction, frame_end marking the last CRC byte.
// A header emits 16 bytes: marker 00 01 x5, timestamp and position
// big-endian. A sample inside a frame emits 2 bytes; the sample completing
// samples_per_frame also emits 4 CRC bytes. Samples outside a frame are
// dropped without output.
// With the queue empty and the output register free, an accepted item is
// written into the command queue, and its first byte then into the output register.
// Throughput: one output byte per cycle while the receiver is ready, set by
// the byte sequencer. A 4-entry command queue lets input run ahead of the
// byte output, e.g. across the 16 header bytes.
// Reset (synchronous, i_rst_n low): no frame open, queue empty, output
// idle, samples_per_frame back to 2490.
// If the receiver stalls, the current byte holds in the output register,
// the queue fills and i_in.ready drops once four commands are waiting.
// samples_per_frame sits at APB byte address 0; write it only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_frame_builder_crc32 (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [sfb_pkg::C_PADDR_W-1:0]  paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    sfb_in_if.sink                         i_in,
    sfb_out_if.source                      o_out
);

    logic [12:0]         r_spf;
    logic                w_push;
    logic                w_pop;
    sfb_pkg::t_cmd       w_cmd;
    sfb_pkg::t_cmd       w_head;
    sfb_pkg::t_q_status  w_q_stat;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sfb_pkg::C_REG_SPF) ? {19'd0, r_spf} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spf <= sfb_pkg::C_SPF_RESET;
        end else if (psel && penable && pwrite && paddr[2] == sfb_pkg::C_REG_SPF) begin
            r_spf <= pwdata[12:0];
        end
    end

    // Front end
    sfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_spf    (r_spf),
        .i_in     (i_in),
        .i_q_full (w_q_stat.full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    // Command queue
    sfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Byte sequencer
    sfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`ifndef ASSERT_OFF
    // The sequencer never retires a command the queue does not hold
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("command retired from empty queue");

    // The front end never pushes into a full queue
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("command pushed into full queue");

    // A closing command that retires loads a frame end byte into the output register
    a_end_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head.kind == sfb_pkg::KIND_LAST) |=> (o_out.valid && o_out.frame_end))
        else $error("closing command retired without frame end byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/sfb_front.sv -----
// ----------------------------------------------------------------------------
// sfb_front: item acceptance and classification
// Tracks the open frame and the sample count, and turns each accepted
// item into a header, sample or frame-closing sample command.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire [12:0]     i_spf,
    sfb_in_if.sink         i_in,
    input  wire            i_q_full,
    output logic           o_push,
    output sfb_pkg::t_cmd  o_cmd
);

    logic        r_open;
    logic [12:0] r_seen;
    logic        n_open;
    logic [12:0] n_seen;
    logic [12:0] w_eff;
    logic [12:0] w_seen_inc;
    logic        w_accept;
    logic        w_closes;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;

    // Effective frame length: zero counts as one, clipped at the maximum
    always_comb begin
        if (i_spf == 13'd0) begin
            w_eff = 13'd1;
        end else if (i_spf > sfb_pkg::C_MAX_SAMPLES) begin
            w_eff = sfb_pkg::C_MAX_SAMPLES;
        end else begin
            w_eff = i_spf;
        end
    end

    assign w_seen_inc = r_seen + 13'd1;
    assign w_closes   = (w_seen_inc >= w_eff);

    // Classify the transaction and update frame state
    always_comb begin
        n_open                 = r_open;
        n_seen                 = r_seen;
        o_push                 = 1'b0;
        o_cmd.kind             = sfb_pkg::KIND_HEADER;
        o_cmd.timestamp        = i_in.timestamp;
        o_cmd.encoder_position = i_in.encoder_position;
        o_cmd.sample           = i_in.sample;
        if (w_accept) begin
            if (!i_in.cmd) begin
                o_push = 1'b1;
                n_open = 1'b1;
                n_seen = 13'd0;
            end else if (r_open) begin
                o_push = 1'b1;
                if (w_closes) begin
                    o_cmd.kind = sfb_pkg::KIND_LAST;
                    n_open     = 1'b0;
                    n_seen     = 13'd0;
                end else begin
                    o_cmd.kind = sfb_pkg::KIND_SAMPLE;
                    n_seen     = w_seen_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_seen <= 13'd0;
        end else begin
            r_open <= n_open;
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfb_fifo.sv -----
// ----------------------------------------------------------------------------
// sfb_fifo: command queue between front end and byte sequencer
// Small register queue; the head entry is presented without a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  sfb_pkg::t_cmd       i_cmd,
    input  wire                 i_pop,
    output sfb_pkg::t_cmd       o_head,
    output sfb_pkg::t_q_status  o_stat
);

    sfb_pkg::t_cmd                   r_mem [sfb_pkg::C_Q_DEPTH];
    logic [sfb_pkg::C_Q_AW-1:0]      r_wr;
    logic [sfb_pkg::C_Q_AW-1:0]      r_rd;
    logic [sfb_pkg::C_Q_CW-1:0]      r_cnt;

    assign o_stat.full  = (r_cnt == sfb_pkg::C_Q_CW'(sfb_pkg::C_Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfb_back.sv -----
// ----------------------------------------------------------------------------
// sfb_back: byte sequencer with CRC-32
// Walks the head command one byte per cycle into the output register while the
// output slot frees up, folding covered bytes into the CRC and appending the trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sfb_pkg::t_cmd       i_head,
    input  sfb_pkg::t_q_status  i_q_stat,
    output logic                o_pop,
    sfb_out_if.source           o_out
);

    logic [3:0]  r_idx;
    logic [31:0] r_crc;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_end;

    logic        w_emit;
    logic        w_last_idx;
    logic [7:0]  w_byte;
    logic        w_fold;
    logic        w_end;
    logic [31:0] w_fin;

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.frame_end = r_end;

    // A byte moves whenever a command waits and the output slot frees up
    assign w_emit = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign w_fin  = ~r_crc;

    // Byte selection per command kind
    always_comb begin
        w_byte     = 8'h00;
        w_fold     = 1'b0;
        w_end      = 1'b0;
        w_last_idx = 1'b0;
        case (i_head.kind)
            sfb_pkg::KIND_HEADER: begin
                w_last_idx = (r_idx == sfb_pkg::C_IDX_HDR_LAST);
                w_fold     = (r_idx > sfb_pkg::C_IDX_MARK_END);
                case (r_idx)
                    4'd10:   w_byte = i_head.timestamp[31:24];
                    4'd11:   w_byte = i_head.timestamp[23:16];
                    4'd12:   w_byte = i_head.timestamp[15:8];
                    4'd13:   w_byte = i_head.timestamp[7:0];
                    4'd14:   w_byte = {4'd0, i_head.encoder_position[11:8]};
                    4'd15:   w_byte = i_head.encoder_position[7:0];
                    default: w_byte = {7'd0, r_idx[0]};  // 00 01 marker
                endcase
            end
            default: begin
                if (i_head.kind == sfb_pkg::KIND_LAST) begin
                    w_last_idx = (r_idx == sfb_pkg::C_IDX_CRC_LAST);
                    w_end      = (r_idx == sfb_pkg::C_IDX_CRC_LAST);
                end else begin
                    w_last_idx = (r_idx == sfb_pkg::C_IDX_SMP_LAST);
                end
                w_fold = (r_idx <= sfb_pkg::C_IDX_SMP_LAST);
                case (r_idx)
                    4'd0:    w_byte = i_head.sample[15:8];
                    4'd1:    w_byte = i_head.sample[7:0];
                    4'd2:    w_byte = w_fin[31:24];
                    4'd3:    w_byte = w_fin[23:16];
                    4'd4:    w_byte = w_fin[15:8];
                    default: w_byte = w_fin[7:0];
                endcase
            end
        endcase
    end

    assign o_pop = w_emit && w_last_idx;

    // Byte index and CRC register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
            r_crc <= sfb_pkg::C_CRC_INIT;
        end else if (w_emit) begin
            r_idx <= w_last_idx ? 4'd0 : r_idx + 4'd1;
            if (i_head.kind == sfb_pkg::KIND_HEADER && r_idx == 4'd0) begin
                r_crc <= sfb_pkg::C_CRC_INIT;
            end else if (w_fold) begin
                r_crc <= sfb_pkg::crc_fold_byte(r_crc, w_byte);
            end else if (w_end) begin
                r_crc <= sfb_pkg::C_CRC_INIT;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= w_byte;
            r_end  <= w_end;
        end
    end

endmodule

`default_nettype wire
